@@ hdl/assert_macros.svh @@
// Assertion helpers, sampled on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge.
`define BMPR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define BMPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bmpr_pkg.sv @@
package bmpr_pkg;

    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int POS_W   = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DOUBLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILHOUETTE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR      = 2'd2;

    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_BAD_FMT = 2'd2;
    localparam logic [1:0] ST_BAD_GEO = 2'd3;

    localparam logic [15:0]        BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0]        BMP_PLANES    = 16'd1;
    localparam logic [15:0]        BMP_BPP       = 16'd24;
    localparam logic [COLOR_W-1:0] SHADE_COLOR   = 16'h2945;
    localparam logic [BYTE_W-1:0]  BYTE_FULL     = 8'hFF;

    localparam logic [POS_W-1:0] POS_SIG    = 32'd1;
    localparam logic [POS_W-1:0] POS_OFFSET = 32'd13;
    localparam logic [POS_W-1:0] POS_WIDTH  = 32'd21;
    localparam logic [POS_W-1:0] POS_HEIGHT = 32'd25;
    localparam logic [POS_W-1:0] POS_FORMAT = 32'd29;
    localparam logic [POS_W-1:0] POS_HDR_END = 32'd33;
    localparam logic [POS_W-1:0] POS_DATA_MIN = 32'd34;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              start_of_file;
    } t_in_word;

    typedef struct packed {
        logic [DIM_W-1:0]   pixel_x;
        logic [DIM_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic [1:0]         status;
        logic               last_of_run;
        logic               image_done;
    } t_out_word;

    // One parsed pixel or error, as handed from parser to writer.
    typedef struct packed {
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [1:0]         status;
        logic               scale;
        logic               done;
    } t_cmd;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v > POS_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM + 1);
        end else begin
            res = v[DIM_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/bmp24_to_rgb565_stream.sv @@
// Once its red byte is taken, a pixel's first word goes through the pixel queue and
// then the writer's output register. Throughput: one byte per cycle while the
// four-entry queue has room; the writer gives one word per cycle while i_out_ready is
// high, so a scaled pixel holds the queue for its four words and limits the stream.
// Reset: synchronous, active low; clears parser state, registers and queue.
module bmp24_to_rgb565_stream
    import bmpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    logic l_accept;
    logic l_cmd_valid;
    t_cmd l_cmd;
    logic l_full, l_empty, l_pop;
    t_cmd l_head;

    assign o_in_ready = !l_full;
    assign l_accept   = i_in_valid && !l_full;

    bmpr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (l_accept),
        .i_in_data   (i_in_data),
        .o_cmd_valid (l_cmd_valid),
        .o_cmd       (l_cmd)
    );

    bmpr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (l_cmd_valid),
        .i_cmd   (l_cmd),
        .i_pop   (l_pop),
        .o_full  (l_full),
        .o_empty (l_empty),
        .o_head  (l_head)
    );

    bmpr_writer u_writer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!l_empty),
        .i_cmd       (l_head),
        .o_pop       (l_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

@@ hdl/bmpr_parser.sv @@
module bmpr_parser
    import bmpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_in_word              i_in_data,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    logic                r_scale, r_silhouette;
    logic [COLOR_W-1:0]  r_fill;

    logic [2:0]          r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_shift, n_shift;
    logic [DIM_W-1:0]    r_width, n_width;
    logic [DIM_W-1:0]    r_height, n_height;
    logic [POS_W-1:0]    r_offset, n_offset;
    logic [DIM_W-1:0]    r_row, n_row;
    logic [DIM_W-1:0]    r_col, n_col;
    logic [1:0]          r_bip, n_bip;
    logic [1:0]          r_pad, n_pad;
    logic [BYTE_W-1:0]   r_blue, n_blue;
    logic [BYTE_W-1:0]   r_green, n_green;
    logic [1:0]          r_rmod, n_rmod;
    logic [1:0]          r_cmod, n_cmod;

    logic [2:0]          l_phase;
    logic [POS_W-1:0]    l_pos;
    logic [POS_W-1:0]    l_shift;
    logic [BYTE_W-1:0]   l_byte;
    logic                l_do_pixel;
    logic [COLOR_W-1:0]  l_color;
    logic                l_key;
    logic [DIM_W-1:0]    l_col_n;
    logic [DIM_W-1:0]    l_row_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= 1'b0;
            r_silhouette <= 1'b0;
            r_fill       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_DOUBLE:    r_scale      <= i_cfg_data[0];
                CFG_SILHOUETTE_MODE: r_silhouette <= i_cfg_data[0];
                CFG_FILL_COLOR:      r_fill       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_width  = r_width;
        n_height = r_height;
        n_offset = r_offset;
        n_row    = r_row;
        n_col    = r_col;
        n_bip    = r_bip;
        n_pad    = r_pad;
        n_blue   = r_blue;
        n_green  = r_green;
        n_rmod   = r_rmod;
        n_cmod   = r_cmod;

        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        l_byte     = i_in_data.byte_value;
        l_phase    = i_in_data.start_of_file ? PH_HEADER : r_phase;
        l_pos      = i_in_data.start_of_file ? '0 : r_pos;
        l_shift    = i_in_data.start_of_file ? '0 : r_shift;
        l_do_pixel = 1'b0;
        l_color    = '0;
        l_key      = 1'b0;
        l_col_n    = DIM_W'(r_col + 1'b1);
        l_row_n    = DIM_W'(r_row + 1'b1);

        if (i_accept) begin
            // Restart drops every parse counter before this byte is taken.
            if (i_in_data.start_of_file) begin
                n_phase  = PH_HEADER;
                n_width  = '0;
                n_height = '0;
                n_offset = '0;
                n_row    = '0;
                n_col    = '0;
                n_bip    = '0;
                n_pad    = '0;
                n_blue   = '0;
                n_green  = '0;
                n_rmod   = '0;
                n_cmod   = '0;
                n_shift  = '0;
            end

            unique case (l_phase)
                PH_HEADER: begin
                    n_shift = {l_byte, l_shift[POS_W-1:BYTE_W]};
                    if (l_pos == POS_SIG && n_shift[31:16] != BMP_SIGNATURE) begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = ST_BAD_SIG;
                        n_phase      = PH_IDLE;
                    end
                    if (l_pos == POS_OFFSET) begin
                        n_offset = n_shift;
                    end
                    if (l_pos == POS_WIDTH) begin
                        n_width = clamp_dim(n_shift);
                    end
                    if (l_pos == POS_HEIGHT) begin
                        n_height = clamp_dim(n_shift);
                    end
                    if (l_pos == POS_FORMAT &&
                        (n_shift[15:0] != BMP_PLANES || n_shift[31:16] != BMP_BPP)) begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = ST_BAD_FMT;
                        n_phase      = PH_IDLE;
                    end
                    if (l_pos == POS_HDR_END) begin
                        if (n_shift != '0) begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.status = ST_BAD_FMT;
                            n_phase      = PH_IDLE;
                        end else if (r_offset < POS_DATA_MIN ||
                                     r_width > DIM_W'(MAX_DIM) ||
                                     r_height > DIM_W'(MAX_DIM)) begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.status = ST_BAD_GEO;
                            n_phase      = PH_IDLE;
                        end else if (r_width == '0 || r_height == '0) begin
                            n_phase = PH_IDLE;
                        end else if (r_offset == POS_DATA_MIN) begin
                            n_phase = PH_PIXEL;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_pos == r_offset) begin
                        n_phase    = PH_PIXEL;
                        l_do_pixel = 1'b1;
                    end
                end
                PH_PIXEL: begin
                    l_do_pixel = 1'b1;
                end
                PH_PAD: begin
                    if (r_pad != '0) begin
                        n_pad = r_pad - 1'b1;
                    end
                    if (n_pad == '0) begin
                        n_phase = PH_PIXEL;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (l_do_pixel) begin
                case (r_bip)
                    2'd0: begin
                        n_blue = l_byte;
                        n_bip  = 2'd1;
                    end
                    2'd1: begin
                        n_green = l_byte;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        n_bip   = 2'd0;
                        l_color = {l_byte[7:3], r_green[7:2], r_blue[7:3]};
                        l_key   = l_byte == BYTE_FULL && r_green == '0 && r_blue == BYTE_FULL;
                        if (r_silhouette && !l_key) begin
                            l_color = (r_rmod == '0 || r_cmod == '0) ? r_fill : SHADE_COLOR;
                        end
                        o_cmd_valid  = 1'b1;
                        o_cmd.col    = r_col;
                        o_cmd.row    = DIM_W'(r_height - r_row - 1'b1);
                        o_cmd.color  = l_color;
                        o_cmd.status = ST_PIXEL;
                        o_cmd.scale  = r_scale;
                        o_cmd.done   = (l_row_n == r_height) && (l_col_n == r_width);

                        // Advance column, then wrap into the next row or finish.
                        n_col  = l_col_n;
                        n_cmod = (r_cmod >= 2'd2) ? 2'd0 : r_cmod + 1'b1;
                        if (l_col_n >= r_width) begin
                            if (l_row_n >= r_height) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_row   = l_row_n;
                                n_rmod  = (r_rmod >= 2'd2) ? 2'd0 : r_rmod + 1'b1;
                                n_col   = '0;
                                n_cmod  = '0;
                                n_pad   = r_width[1:0];
                                n_phase = (r_width[1:0] != '0) ? PH_PAD : PH_PIXEL;
                            end
                        end
                    end
                endcase
            end

            // Hold the byte count at its ceiling on very long files.
            n_pos = (l_pos != '1) ? l_pos + 1'b1 : l_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_shift  <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_offset <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_bip    <= '0;
            r_pad    <= '0;
            r_blue   <= '0;
            r_green  <= '0;
            r_rmod   <= '0;
            r_cmod   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_width  <= n_width;
            r_height <= n_height;
            r_offset <= n_offset;
            r_row    <= n_row;
            r_col    <= n_col;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
            r_blue   <= n_blue;
            r_green  <= n_green;
            r_rmod   <= n_rmod;
            r_cmod   <= n_cmod;
        end
    end

endmodule

@@ hdl/bmpr_cmd_fifo.sv @@
module bmpr_cmd_fifo
    import bmpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_CW-1:0] r_count;
    logic               l_push, l_pop;

    assign o_full  = r_count == FIFO_CW'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];
    assign l_push  = i_push && !o_full;
    assign l_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (l_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (l_push) begin
                r_wr <= FIFO_AW'(r_wr + 1'b1);
            end
            if (l_pop) begin
                r_rd <= FIFO_AW'(r_rd + 1'b1);
            end
            case ({l_push, l_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/bmpr_writer.sv @@
`include "assert_macros.svh"

module bmpr_writer
    import bmpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  logic      i_out_ready
);

    logic       r_out_valid;
    t_out_word  r_out, n_out;
    logic [1:0] r_sub;
    logic       l_load, l_last;

    assign l_load = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign l_last = !i_cmd.scale || r_sub == 2'd3;
    assign o_pop  = l_load && l_last;

    always_comb begin
        n_out             = '0;
        n_out.pixel_color = i_cmd.color;
        n_out.status      = i_cmd.status;
        n_out.last_of_run = l_last;
        n_out.image_done  = i_cmd.done && l_last;
        if (i_cmd.scale) begin
            // Sub-index bit 0 picks the column of the block, bit 1 the row.
            n_out.pixel_x = {i_cmd.col[DIM_W-2:0], r_sub[0]};
            n_out.pixel_y = {i_cmd.row[DIM_W-2:0], r_sub[1]};
        end else begin
            n_out.pixel_x = i_cmd.col;
            n_out.pixel_y = i_cmd.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= '0;
        end else begin
            if (l_load) begin
                r_out_valid <= 1'b1;
                r_sub       <= l_last ? 2'd0 : r_sub + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BMPR_ASSERT_NEXT(a_block_continues, r_out_valid && i_out_ready && !r_out.last_of_run, r_out_valid, "scaled block broke off before its last word")
    `BMPR_ASSERT_SAME(a_done_is_last, r_out_valid && r_out.image_done, r_out.last_of_run, "image done on a word that is not last of run")
    `BMPR_ASSERT_SAME(a_sub_has_head, r_sub != 2'd0, i_cmd_valid, "block in progress without a queued pixel")
    `BMPR_ASSERT_SAME(a_error_zero, r_out_valid && r_out.status != ST_PIXEL, r_out.pixel_x == '0 && r_out.pixel_y == '0 && r_out.pixel_color == '0, "error word carries nonzero payload")

endmodule
